// ----- rtl/irpd_pkg.sv -----
// types and constants for the infrared pulse-distance frame decoder
// no dependencies; used by the top level
`timescale 1ns / 1ps

package irpd_pkg;

  // nominal timings in microseconds
  localparam logic [15:0] HDR_MARK   = 16'd3502;
  localparam logic [15:0] HDR_SPACE  = 16'd1750;
  localparam logic [15:0] BIT_MARK   = 16'd502;
  localparam logic [15:0] ZERO_SPACE = 16'd400;
  localparam logic [15:0] ONE_SPACE  = 16'd1244;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CMD_W      = 32;
  localparam int unsigned TOTAL_BITS = ADDR_W + CMD_W;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned TOL_W      = 7;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  // wide enough for 65535 * 100 and 3502 * 227
  localparam int unsigned PROD_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CMD = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BITS = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef struct packed {
    logic        frame_start;
    logic [15:0] mark_us;
    logic [15:0] space_us;
  } pulse_t;

  typedef struct packed {
    logic              frame_valid;
    logic [ADDR_W-1:0] rx_address;
    logic [CMD_W-1:0]  rx_command;
    logic              matched;
  } frame_t;

endpackage

// ----- rtl/irpd_stream_if.sv -----
// valid/ready stream channel carrying one payload of type T
// payload types come from irpd_pkg
`timescale 1ns / 1ps

interface irpd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ir_pulse_distance_frame_decoder.sv -----
// channel     dir  payload                                           handshake
// pulse_i     in   frame_start, mark_us, space_us                    valid/ready
// result_o    out  frame_valid, rx_address, rx_command, matched      valid/ready
// cfg port    in   cfg_idx_i, cfg_wdata_i                            cfg_we_i, no wait
//
// one pulse per cycle: each request is checked against the header or bit
// timings and the frame state is updated in the same cycle; a result is
// held in the output register and shows in the cycle after its pulse.
// input stalls only while a result waits and result_o.ready is low.
// reset returns to idle (waiting for frame start) with tolerance 25 percent.
// depends on irpd_pkg and irpd_stream_if
`timescale 1ns / 1ps

module ir_pulse_distance_frame_decoder
  import irpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  irpd_stream_if.sink          pulse_i,
  irpd_stream_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // d within n * (100 -/+ tol) / 100, both bounds inclusive
  function automatic logic in_window(input logic [15:0] d, input logic [15:0] n,
                                     input logic [TOL_W-1:0] tol);
    logic [PROD_W-1:0] v;
    logic [PROD_W-1:0] hi;
    logic [PROD_W-1:0] lo;
    v  = PROD_W'(d) * PROD_W'(100);
    hi = PROD_W'(n) * (PROD_W'(100) + PROD_W'(tol));
    if (tol < TOL_W'(100)) begin
      lo = PROD_W'(n) * PROD_W'(TOL_W'(100) - tol);
    end else begin
      lo = '0;
    end
    return (v >= lo) && (v <= hi);
  endfunction

  logic [TOL_W-1:0]      tol_q;
  logic [ADDR_W-1:0]     match_addr_q;
  logic [CMD_W-1:0]      match_cmd_q;

  phase_e                phase_q, phase_d;
  logic [CNT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [TOTAL_BITS-1:0] shift_q, shift_d;

  logic                  out_valid_q;
  frame_t                out_q;
  frame_t                res;
  logic                  res_load;
  logic                  in_fire;

  logic                  hdr_ok, one_ok, zero_ok;
  logic [CNT_W-1:0]      bit_idx;

  assign pulse_i.ready  = !out_valid_q || result_o.ready;
  assign in_fire        = pulse_i.valid && pulse_i.ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  assign hdr_ok  = in_window(pulse_i.data.mark_us, HDR_MARK, tol_q)
                && in_window(pulse_i.data.space_us, HDR_SPACE, tol_q);
  assign one_ok  = in_window(pulse_i.data.mark_us, BIT_MARK, tol_q)
                && in_window(pulse_i.data.space_us, ONE_SPACE, tol_q);
  assign zero_ok = in_window(pulse_i.data.mark_us, BIT_MARK, tol_q)
                && in_window(pulse_i.data.space_us, ZERO_SPACE, tol_q);
  // msb first: bit n of the frame lands at position 47 - n
  assign bit_idx = CNT_W'(TOTAL_BITS - 1) - bit_cnt_q;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    res_load  = 1'b0;
    res.frame_valid = 1'b0;
    if (in_fire) begin
      priority if (pulse_i.data.frame_start) begin
        bit_cnt_d = '0;
        shift_d   = '0;
        if (hdr_ok) begin
          phase_d = PH_BITS;
        end else begin
          phase_d  = PH_DONE;
          res_load = 1'b1;
        end
      end else if (phase_q == PH_BITS) begin
        if (one_ok || zero_ok) begin
          if (one_ok) begin
            shift_d[bit_idx] = 1'b1;
          end
          bit_cnt_d = bit_cnt_q + CNT_W'(1);
          if (bit_cnt_q == CNT_W'(TOTAL_BITS - 1)) begin
            phase_d         = PH_DONE;
            res_load        = 1'b1;
            res.frame_valid = 1'b1;
          end
        end else begin
          phase_d  = PH_DONE;
          res_load = 1'b1;
        end
      end else begin
        // idle or done: pulse dropped
        phase_d = phase_q;
      end
    end
    res.rx_address = shift_d[TOTAL_BITS-1 -: ADDR_W];
    res.rx_command = shift_d[CMD_W-1:0];
    res.matched    = res.frame_valid && (res.rx_address == match_addr_q)
                  && (res.rx_command == match_cmd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= TOL_RESET;
      match_addr_q <= '0;
      match_cmd_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOLERANCE:  tol_q        <= cfg_wdata_i[TOL_W-1:0];
        CFG_MATCH_ADDR: match_addr_q <= cfg_wdata_i[ADDR_W-1:0];
        CFG_MATCH_CMD:  match_cmd_q  <= cfg_wdata_i[CMD_W-1:0];
        default:        tol_q        <= tol_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

`ifndef ASSERT_OFF
  a_result_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (phase_q == PH_DONE && out_valid_q))
    else $error("result load did not end the frame");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BITS) |-> (bit_cnt_q < CNT_W'(TOTAL_BITS)))
    else $error("bit count past frame length while decoding");

  a_valid_has_all_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res.frame_valid) |=> (bit_cnt_q == CNT_W'(TOTAL_BITS)))
    else $error("valid frame without all bits");

  a_matched_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.matched || out_q.frame_valid))
    else $error("matched set on invalid frame");
`endif

endmodule
